[rtl/vrlt_pkg.sv]
// Shared types and constants of the voxel run-length table.
`default_nettype none
package vrlt_pkg;

   localparam int EDGE_W   = 5;
   localparam int INDEX_W  = 12;
   localparam int VOXEL_W  = 16;
   localparam int STATUS_W = 3;
   localparam int START_W  = 13;
   localparam int TYPE_W   = 16;
   localparam int TOTAL_W  = 13;

   localparam logic [EDGE_W-1:0] EDGE_RESET = 5'd16;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_SAME     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

   typedef struct packed {
      logic               req_type;
      logic [VOXEL_W-1:0] voxel_type;
      logic [INDEX_W-1:0] lookup_index;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  run_start;
      logic [TYPE_W-1:0]   run_type;
      logic [TOTAL_W-1:0]  run_total;
   } rsp_word_type;

   typedef struct packed {
      logic latch;
      logic cfg_write;
      logic load_step;
      logic lookup_step;
      logic term_step;
      logic scan_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic overflow;
      logic final_voxel;
      logic refused;
      logic hit;
   } dp_status_type;

endpackage
`default_nettype wire

[rtl/voxel_run_length_table.sv]
// Top level of the voxel run-length table: sequencer plus datapath.
//
//   channel   ports                           handshake
//   request   start, busy, req_word           taken when start & !busy
//   result    rsp_strobe, rsp_word            one-cycle strobe, no backpressure
//   csr       csr_valid, csr_ready, csr_data  taken when csr_valid & csr_ready
//
// A load runs the execute state, and then the terminator state when it is
// the last voxel of the chunk (the terminator is a second write to the store).
// A lookup runs the execute state, then scans for its run: the store has one
// read port and the scan reads one entry per cycle; a refused lookup ends
// after the execute state. A csr write keeps the block busy while the
// two-stage volume multiply settles, and so does reset; the result is shown in
// the cycle after the item's last busy cycle and the receiver cannot stall it.
`default_nettype none
module voxel_run_length_table #(
   parameter int MAX_EDGE  = 16,
   parameter int TYPE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  vrlt_pkg::req_word_type      req_word,
   output logic                        rsp_strobe,
   output vrlt_pkg::rsp_word_type      rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [vrlt_pkg::EDGE_W-1:0] csr_data
);
   import vrlt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   vrlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .csr_valid  (csr_valid),
      .st         (st),
      .busy       (busy),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   vrlt_dp #(
      .MAX_EDGE  (MAX_EDGE),
      .TYPE_BITS (TYPE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .csr_data (csr_data),
      .cmd      (cmd),
      .st       (st),
      .rsp_word (rsp_word)
   );

endmodule
`default_nettype wire

[rtl/vrlt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module vrlt_ram #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 4097
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/vrlt_ctrl.sv]
// Sequencer of the voxel run-length table: handshakes and datapath commands.
`default_nettype none
module vrlt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    csr_valid,
   input  vrlt_pkg::dp_status_type st,
   output logic                    busy,
   output logic                    csr_ready,
   output logic                    rsp_strobe,
   output vrlt_pkg::ctrl_cmd_type  cmd
);
   import vrlt_pkg::*;

   typedef enum logic [2:0] {
      S_SET1,
      S_SET2,
      S_IDLE,
      S_EXEC,
      S_TERM,
      S_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_SET1: begin
            state_in = S_SET2;
         end
         S_SET2: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end else if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               state_in      = S_SET1;
            end
         end
         S_EXEC: begin
            if (st.is_lookup) begin
               cmd.lookup_step = 1'b1;
               if (st.refused) begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               cmd.load_step = 1'b1;
               if (!st.overflow && st.final_voxel) begin
                  state_in = S_TERM;
               end else begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_TERM: begin
            cmd.term_step = 1'b1;
            strobe_in     = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            if (st.hit) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_SET1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE) && !start;
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

[rtl/vrlt_dp.sv]
// Datapath of the voxel run-length table: chunk volume, run store, load and scan logic.
`default_nettype none
module vrlt_dp #(
   parameter int MAX_EDGE  = 16,
   parameter int TYPE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vrlt_pkg::req_word_type        req_word,
   input  logic [vrlt_pkg::EDGE_W-1:0]   csr_data,
   input  vrlt_pkg::ctrl_cmd_type        cmd,
   output vrlt_pkg::dp_status_type       st,
   output vrlt_pkg::rsp_word_type        rsp_word
);
   import vrlt_pkg::*;

   localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE + 1;
   localparam int POS_W = $clog2(DEPTH);
   localparam int AW    = POS_W;
   localparam int ENT_W = $clog2(DEPTH + 1);
   localparam int EC_W  = $clog2(MAX_EDGE + 1);
   localparam int SW    = (TYPE_BITS < TYPE_W) ? TYPE_BITS : TYPE_W;
   localparam int CMP_W = (POS_W > INDEX_W) ? POS_W : INDEX_W;
   localparam int ROW_W = POS_W + SW;

   localparam logic [EDGE_W:0]  EDGE_MAX = (EDGE_W + 1)'(MAX_EDGE);
   localparam logic [EDGE_W:0]  EDGE_MIN = (EDGE_W + 1)'(1);
   localparam logic [ENT_W-1:0] DEPTH_E  = ENT_W'(DEPTH);
   localparam logic [ENT_W-1:0] ENT_ONE  = ENT_W'(1);
   localparam logic [ENT_W-1:0] ENT_TWO  = ENT_W'(2);

   req_word_type        req_ff;
   logic [EDGE_W-1:0]   edge_ff;
   logic [2*EC_W-1:0]   sq_ff, sq_in;
   logic [POS_W-1:0]    vol_ff, vol_in;
   logic [ENT_W-1:0]    entries_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [SW-1:0]       open_type_ff;
   logic [POS_W-1:0]    open_start_ff;
   logic                done_ff;
   logic [POS_W-1:0]    term_start_ff;
   logic [ENT_W-1:0]    ptr_ff;
   logic                data_valid_ff;
   logic [ENT_W-1:0]    data_j_ff;
   logic [POS_W-1:0]    prev_start_ff;
   logic [SW-1:0]       prev_type_ff;
   rsp_word_type        rsp_ff;

   logic [EDGE_W:0]     edge_ext, edge_c;
   logic [EC_W-1:0]     ec;
   logic [3*EC_W-1:0]   cube;
   logic [SW-1:0]       typ;
   logic [POS_W-1:0]    pos_eff;
   logic [ENT_W-1:0]    ent_eff;
   logic [SW-1:0]       open_eff;
   logic [POS_W:0]      pos_next;
   logic                overflow, final_voxel, is_new, room, term_room, refused, hit;
   logic [ENT_W-1:0]    ent_after;
   logic [CMP_W-1:0]    idx_ext, limit_ext;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ROW_W-1:0]    wr_data, rd_data;
   logic [POS_W-1:0]    rd_start;
   logic [SW-1:0]       rd_type;

   always_comb begin
      edge_ext = {1'b0, edge_ff};
      if (edge_ext < EDGE_MIN) begin
         edge_c = EDGE_MIN;
      end else if (edge_ext > EDGE_MAX) begin
         edge_c = EDGE_MAX;
      end else begin
         edge_c = edge_ext;
      end
   end

   assign ec     = edge_c[EC_W-1:0];
   assign sq_in  = (2*EC_W)'(ec) * (2*EC_W)'(ec);
   assign cube   = (3*EC_W)'(sq_ff) * (3*EC_W)'(ec);
   assign vol_in = cube[POS_W-1:0];

   assign typ      = req_ff.voxel_type[SW-1:0];
   assign pos_eff  = done_ff ? '0 : pos_ff;
   assign ent_eff  = done_ff ? '0 : entries_ff;
   assign open_eff = done_ff ? '0 : open_type_ff;
   assign pos_next = {1'b0, pos_eff} + (POS_W + 1)'(1);

   assign overflow    = (pos_eff >= vol_ff);
   assign final_voxel = (pos_next == {1'b0, vol_ff});
   assign is_new      = (pos_eff == '0) || (ent_eff == '0) || (typ != open_eff);
   assign room        = (ent_eff < DEPTH_E);
   assign term_room   = (entries_ff < DEPTH_E);
   assign ent_after   = (is_new && room) ? ent_eff + ENT_ONE : ent_eff;

   assign idx_ext   = CMP_W'(req_ff.lookup_index);
   assign limit_ext = CMP_W'(term_start_ff);
   assign refused   = !done_ff || (entries_ff < ENT_TWO) || (idx_ext >= limit_ext);

   assign rd_start = rd_data[ROW_W-1:SW];
   assign rd_type  = rd_data[SW-1:0];
   assign hit      = data_valid_ff && (data_j_ff != '0) && (CMP_W'(rd_start) > idx_ext);

   assign wr_en   = (cmd.load_step && !overflow && is_new && room)
                 || (cmd.term_step && term_room);
   assign wr_addr = cmd.term_step ? entries_ff[AW-1:0] : ent_eff[AW-1:0];
   assign wr_data = cmd.term_step ? {pos_ff, SW'(0)} : {pos_eff, typ};

   vrlt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff       <= EDGE_RESET;
         entries_ff    <= '0;
         pos_ff        <= '0;
         open_type_ff  <= '0;
         done_ff       <= 1'b0;
         data_valid_ff <= 1'b0;
      end else begin
         if (cmd.cfg_write) begin
            edge_ff <= csr_data;
         end
         if (cmd.load_step && !overflow) begin
            entries_ff   <= ent_after;
            pos_ff       <= pos_next[POS_W-1:0];
            open_type_ff <= is_new ? typ : open_eff;
            done_ff      <= 1'b0;
         end
         if (cmd.term_step) begin
            if (term_room) begin
               entries_ff <= entries_ff + ENT_ONE;
            end
            done_ff <= 1'b1;
         end
         data_valid_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      vol_ff <= vol_in;
      if (cmd.latch) begin
         req_ff <= req_word;
      end
      if (cmd.load_step && !overflow && is_new) begin
         open_start_ff <= pos_eff;
      end
      if (cmd.term_step) begin
         term_start_ff <= pos_ff;
      end
      if (cmd.lookup_step) begin
         ptr_ff <= '0;
      end else if (cmd.scan_step) begin
         ptr_ff <= ptr_ff + ENT_ONE;
      end
      if (cmd.scan_step) begin
         data_j_ff <= ptr_ff;
      end
      if (data_valid_ff) begin
         prev_start_ff <= rd_start;
         prev_type_ff  <= rd_type;
      end
      if (cmd.load_step) begin
         if (overflow) begin
            rsp_ff <= '{status: ST_OVERFLOW, run_start: '0, run_type: '0,
                        run_total: TOTAL_W'(entries_ff)};
         end else begin
            rsp_ff <= '{status:    is_new ? ST_NEW : ST_SAME,
                        run_start: START_W'(is_new ? pos_eff : open_start_ff),
                        run_type:  TYPE_W'(typ),
                        run_total: TOTAL_W'(ent_after)};
         end
      end else if (cmd.term_step) begin
         rsp_ff.run_total <= TOTAL_W'(term_room ? entries_ff + ENT_ONE : entries_ff);
      end else if (cmd.lookup_step && refused) begin
         rsp_ff <= '{status: ST_REFUSED, run_start: '0, run_type: '0,
                     run_total: TOTAL_W'(entries_ff)};
      end else if (hit) begin
         rsp_ff <= '{status:    ST_HIT,
                     run_start: START_W'(prev_start_ff),
                     run_type:  TYPE_W'(prev_type_ff),
                     run_total: TOTAL_W'(entries_ff)};
      end
   end

   assign st.is_lookup   = (req_ff.req_type == REQ_LOOKUP);
   assign st.overflow    = overflow;
   assign st.final_voxel = final_voxel;
   assign st.refused     = refused;
   assign st.hit         = hit;
   assign rsp_word       = rsp_ff;

endmodule
`default_nettype wire

[rtl/vrlt_checker.sv]
// Port-level assertions of the voxel run-length table and their bind.
`default_nettype none
module vrlt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input vrlt_pkg::rsp_word_type rsp_word,
   input logic                   csr_ready
);
   import vrlt_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a preceding busy cycle");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> (!busy && !start))
      else $error("csr ready while a word is in progress");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.status == ST_SAME || rsp_word.status == ST_NEW ||
                      rsp_word.status == ST_HIT || rsp_word.status == ST_REFUSED ||
                      rsp_word.status == ST_OVERFLOW))
      else $error("result word with unknown status");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status == ST_REFUSED || rsp_word.status == ST_OVERFLOW))
      |-> (rsp_word.run_start == '0 && rsp_word.run_type == '0))
      else $error("refused or overflow word carries a run");

endmodule

bind voxel_run_length_table vrlt_checker u_vrlt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word),
   .csr_ready  (csr_ready)
);
`default_nettype wire
